// ----- hdl/drr_pkg.sv -----
// ----------------------------------------------------------------------------
// drr_pkg
// shared widths, codes and beat types of the receive reorder engine
// ----------------------------------------------------------------------------
package drr_pkg;

    localparam int CHAN_W       = 3;
    localparam int SEQ_W        = 16;
    localparam int HANDLE_W     = 10;
    // slot offset sized for the largest supported window
    localparam int OFF_W        = 6;

    localparam int DEF_WINDOW   = 32;
    localparam int DEF_CHANNELS = 8;
    localparam int QUEUE_DEPTH  = 2;

    // distances from here up count as already seen
    localparam logic [SEQ_W-1:0] DUP_LIMIT = 16'h8000;

    typedef enum logic [1:0] {
        ST_IN_ORDER  = 2'd0,
        ST_BUFFERED  = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_BEYOND    = 2'd3
    } ack_status_t;

    typedef enum logic {
        RK_ACK     = 1'b0,
        RK_DELIVER = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        OP_ACK     = 2'd0,
        OP_STORE   = 2'd1,
        OP_INORDER = 2'd2
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE    = 2'd0,
        BK_ACK     = 2'd1,
        BK_DELIVER = 2'd2,
        BK_DRAIN   = 2'd3
    } back_state_t;

    typedef struct packed {
        cmd_op_t               op;
        ack_status_t           status;
        logic [CHAN_W-1:0]     channel;
        logic [SEQ_W-1:0]      index;
        logic [HANDLE_W-1:0]   handle;
        logic [OFF_W-1:0]      slot_off;
    } cmd_t;

    // end of an in-order run: new expected number of the channel
    typedef struct packed {
        logic                  valid;
        logic [CHAN_W-1:0]     channel;
        logic [SEQ_W-1:0]      seq;
        logic [OFF_W-1:0]      off;
    } done_t;

endpackage

// ----- hdl/drr_ram.sv -----
// ----------------------------------------------------------------------------
// drr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module drr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/drr_queue.sv -----
// ----------------------------------------------------------------------------
// drr_queue
// short command queue between the classifier and the sequencer
// ----------------------------------------------------------------------------
module drr_queue
    import drr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/drr_front.sv -----
// ----------------------------------------------------------------------------
// drr_front
// takes packet beats, classifies them against the expected number of the
// channel and queues one command per packet
// ----------------------------------------------------------------------------
module drr_front
    import drr_pkg::*;
#(
    parameter int WINDOW   = DEF_WINDOW,
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [SEQ_W-1:0]    seq_index,
    input  logic [HANDLE_W-1:0] payload_handle,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_cmd,
    input  done_t               done
);

    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                in_full_reg, in_full_next;
    logic [CHAN_W-1:0]   in_ch_reg;
    logic [SEQ_W-1:0]    in_seq_reg;
    logic [HANDLE_W-1:0] in_handle_reg;

    logic [SEQ_W-1:0]    exp_seq_reg [CHANNELS];
    logic [OFF_W-1:0]    exp_off_reg [CHANNELS];
    logic [CHANNELS-1:0] pending_reg, pending_next;

    logic                accept;
    logic                advance;
    logic                hazard;
    logic                ch_ok;
    logic [CH_IW-1:0]    ch_idx;
    logic [CH_IW-1:0]    done_idx;
    logic [SEQ_W-1:0]    exp_seq;
    logic [OFF_W-1:0]    exp_off;
    logic [SEQ_W-1:0]    diff;
    logic                wrapped;
    logic [OFF_W:0]      off_sum;
    logic [OFF_W:0]      off_mod;

    assign ch_ok    = ({1'b0, in_ch_reg} < (CHAN_W + 1)'(CHANNELS));
    assign ch_idx   = in_ch_reg[CH_IW-1:0];
    assign done_idx = done.channel[CH_IW-1:0];
    assign exp_seq  = exp_seq_reg[ch_idx];
    assign exp_off  = exp_off_reg[ch_idx];

    // a channel with an in-order run in flight waits for its new expected number
    assign hazard   = ch_ok && pending_reg[ch_idx];
    assign advance  = in_full_reg && !q_full && !hazard;
    assign in_stall = in_full_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign q_push   = advance;

    assign diff    = in_seq_reg - exp_seq;
    assign wrapped = (in_seq_reg < exp_seq);
    assign off_sum = {1'b0, exp_off} + {1'b0, diff[OFF_W-1:0]};
    assign off_mod = (off_sum >= (OFF_W + 1)'(WINDOW)) ? off_sum - (OFF_W + 1)'(WINDOW)
                                                       : off_sum;

    always_comb
    begin
        q_cmd.op      = OP_ACK;
        q_cmd.status  = ST_BEYOND;
        q_cmd.channel = in_ch_reg;
        q_cmd.index   = in_seq_reg;
        q_cmd.handle  = in_handle_reg;
        // past the index wrap the index itself is below the window
        q_cmd.slot_off = wrapped ? in_seq_reg[OFF_W-1:0] : off_mod[OFF_W-1:0];
        if (ch_ok)
        begin
            if (diff == '0)
            begin
                q_cmd.op     = OP_INORDER;
                q_cmd.status = ST_IN_ORDER;
            end
            else if (diff < SEQ_W'(WINDOW))
            begin
                q_cmd.op     = OP_STORE;
                q_cmd.status = ST_BUFFERED;
            end
            else if (diff < DUP_LIMIT)
            begin
                q_cmd.status = ST_BEYOND;
            end
            else
            begin
                q_cmd.status = ST_DUPLICATE;
            end
        end
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end

        pending_next = pending_reg;
        if (done.valid)
        begin
            pending_next[done_idx] = 1'b0;
        end
        if (advance && ch_ok && q_cmd.op == OP_INORDER)
        begin
            pending_next[ch_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            pending_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                exp_seq_reg[i] <= '0;
                exp_off_reg[i] <= '0;
            end
        end
        else
        begin
            in_full_reg <= in_full_next;
            pending_reg <= pending_next;
            if (done.valid)
            begin
                exp_seq_reg[done_idx] <= done.seq;
                exp_off_reg[done_idx] <= done.off;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_ch_reg     <= channel;
            in_seq_reg    <= seq_index;
            in_handle_reg <= payload_handle;
        end
    end

endmodule

// ----- hdl/drr_back.sv -----
// ----------------------------------------------------------------------------
// drr_back
// carries out queued commands: acks, slot stores, in-order delivery and the
// drain of consecutive buffered slots, up to one result beat per unstalled cycle
// ----------------------------------------------------------------------------
module drr_back
    import drr_pkg::*;
#(
    parameter int WINDOW   = DEF_WINDOW,
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  cmd_t                q_head,
    output logic                q_pop,
    output done_t               done,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                result_kind,
    output logic [CHAN_W-1:0]   out_channel,
    output logic [SEQ_W-1:0]    out_index,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [1:0]          ack_status,
    output logic                last
);

    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    function automatic logic [AW-1:0] slot_addr(input logic [CHAN_W-1:0] ch,
                                                input logic [OFF_W-1:0]  off);
        slot_addr = AW'(int'(ch[CH_IW-1:0]) * WINDOW + int'(off));
    endfunction

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [SEQ_W-1:0]    e_reg, e_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [OFF_W-1:0]    cnt_reg, cnt_next;
    logic [DEPTH-1:0]    valid_reg;

    logic                out_valid_reg;
    result_kind_t        out_kind_reg, o_kind;
    logic [CHAN_W-1:0]   out_ch_reg;
    logic [SEQ_W-1:0]    out_index_reg, o_index;
    logic [HANDLE_W-1:0] out_handle_reg, o_handle;
    ack_status_t         out_status_reg, o_status;
    logic                out_last_reg, o_last;
    logic                out_load;
    logic                out_free;

    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       nxt_addr;
    logic [AW-1:0]       raddr;
    logic [SEQ_W-1:0]    nxt_e;
    logic [OFF_W-1:0]    nxt_off;
    logic                nxt_live;
    logic                more_ok;
    logic                v_we;
    logic                v_val;
    logic                ram_we;
    logic [HANDLE_W-1:0] rdata;

    drr_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_addr),
        .wdata (cmd_reg.handle),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign cur_addr = slot_addr(cmd_reg.channel, off_reg);
    assign nxt_e    = e_reg + 1'b1;
    // offset follows the index, restarting at zero at the window end and where the index wraps
    assign nxt_off  = (e_reg == '1) ? '0 :
                      (off_reg == OFF_W'(WINDOW - 1)) ? '0 : off_reg + 1'b1;
    assign nxt_addr = slot_addr(cmd_reg.channel, nxt_off);
    // the slot being cleared now may alias the next one across the wrap
    assign nxt_live = valid_reg[nxt_addr] && (nxt_addr != cur_addr);
    assign more_ok  = (cnt_reg < OFF_W'(WINDOW - 2));

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        e_next     = e_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        o_kind     = RK_ACK;
        o_index    = e_reg;
        o_handle   = '0;
        o_status   = ST_IN_ORDER;
        o_last     = 1'b0;
        v_we       = 1'b0;
        v_val      = 1'b0;
        ram_we     = 1'b0;
        raddr      = cur_addr;
        done       = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    e_next     = q_head.index;
                    off_next   = q_head.slot_off;
                    cnt_next   = '0;
                    state_next = BK_ACK;
                end
            end
            BK_ACK:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    o_index  = cmd_reg.index;
                    o_status = cmd_reg.status;
                    o_last   = (cmd_reg.op != OP_INORDER);
                    case (cmd_reg.op)
                        OP_STORE:
                        begin
                            v_we       = 1'b1;
                            v_val      = 1'b1;
                            ram_we     = 1'b1;
                            state_next = BK_IDLE;
                        end
                        OP_INORDER:
                        begin
                            v_we       = 1'b1;
                            state_next = BK_DELIVER;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_DELIVER:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    o_kind   = RK_DELIVER;
                    o_handle = cmd_reg.handle;
                    o_last   = !nxt_live;
                    e_next   = nxt_e;
                    off_next = nxt_off;
                    raddr    = nxt_addr;
                    if (nxt_live)
                    begin
                        state_next = BK_DRAIN;
                    end
                    else
                    begin
                        done       = '{valid: 1'b1, channel: cmd_reg.channel,
                                       seq: nxt_e, off: nxt_off};
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_DRAIN:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    o_kind   = RK_DELIVER;
                    o_handle = rdata;
                    o_last   = !(more_ok && nxt_live);
                    v_we     = 1'b1;
                    e_next   = nxt_e;
                    off_next = nxt_off;
                    cnt_next = cnt_reg + 1'b1;
                    raddr    = nxt_addr;
                    if (!(more_ok && nxt_live))
                    begin
                        done       = '{valid: 1'b1, channel: cmd_reg.channel,
                                       seq: nxt_e, off: nxt_off};
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            if (v_we)
            begin
                valid_reg[cur_addr] <= v_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        e_reg   <= e_next;
        off_reg <= off_next;
        cnt_reg <= cnt_next;
        if (out_load)
        begin
            out_kind_reg   <= o_kind;
            out_ch_reg     <= cmd_reg.channel;
            out_index_reg  <= o_index;
            out_handle_reg <= o_handle;
            out_status_reg <= o_status;
            out_last_reg   <= o_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign out_channel = out_ch_reg;
    assign out_index   = out_index_reg;
    assign out_handle  = out_handle_reg;
    assign ack_status  = out_status_reg;
    assign last        = out_last_reg;

endmodule

// ----- hdl/drw_receive_reorder_top.sv -----
// ----------------------------------------------------------------------------
// drw_receive_reorder_top
// per-channel receive reorder engine: acks every packet, delivers in-order
// payload handles and drains buffered slots of the window in sequence
// ----------------------------------------------------------------------------
//  channel  | handshake            | beat contents
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | channel, seq_index, payload_handle
//  out      | out_valid / out_stall| result_kind, out_channel, out_index,
//           |                      | out_handle, ack_status, last
//
//  a packet passes the input register and the command queue, then the back end
//  gives one result beat per cycle while out_stall is low: an ack, plus one
//  delivery and one per drained slot for an in-order packet; the drain walks
//  the slot ram one entry per cycle via its read port while out_stall is low
//  a packet on a channel with an in-order run still in flight waits in the
//  input register and blocks later ones; others pass the 2-entry command queue
//  reset clears expected numbers and slot valid flops at once; out_stall
//  holds the output register and backs up into the queue
// ----------------------------------------------------------------------------
module drw_receive_reorder_top
    import drr_pkg::*;
#(
    parameter int WINDOW   = DEF_WINDOW,
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [SEQ_W-1:0]    seq_index,
    input  logic [HANDLE_W-1:0] payload_handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                result_kind,
    output logic [CHAN_W-1:0]   out_channel,
    output logic [SEQ_W-1:0]    out_index,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [1:0]          ack_status,
    output logic                last
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_empty;
    cmd_t  q_cmd;
    cmd_t  q_head;
    done_t done;

    drr_front #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .channel        (channel),
        .seq_index      (seq_index),
        .payload_handle (payload_handle),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_cmd),
        .done           (done)
    );

    drr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    drr_back #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .done        (done),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .out_channel (out_channel),
        .out_index   (out_index),
        .out_handle  (out_handle),
        .ack_status  (ack_status),
        .last        (last)
    );

endmodule

// ----- hdl/drr_checker.sv -----
// ----------------------------------------------------------------------------
// drr_checker
// port level checks of the result stream of the reorder engine
// ----------------------------------------------------------------------------
module drr_checker
    import drr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic                result_kind,
    input logic [CHAN_W-1:0]   out_channel,
    input logic [SEQ_W-1:0]    out_index,
    input logic [HANDLE_W-1:0] out_handle,
    input logic [1:0]          ack_status,
    input logic                last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_index)
            && $stable(out_handle) && $stable(last) && $stable(result_kind))
        else $error("result beat changed while stalled");

    // only an in-order ack is followed by deliveries
    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RK_ACK
            |-> (last == (ack_status != ST_IN_ORDER)))
        else $error("ack last flag disagrees with its status");

    // acks carry no handle, deliveries carry status zero
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == RK_ACK && out_handle == '0)
            || (result_kind == RK_DELIVER && ack_status == ST_IN_ORDER))
        else $error("result fields inconsistent with kind");

    // within one run deliveries step by one index on the same channel
    a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last
            ##1 out_valid && result_kind == RK_DELIVER
            |-> out_channel == $past(out_channel, 1)
                && (out_index == $past(out_index, 1)
                    || out_index == $past(out_index, 1) + 16'd1)
                && ($past(result_kind, 1) == RK_ACK || out_index != $past(out_index, 1)))
        else $error("delivery run broke sequence");

endmodule

bind drw_receive_reorder_top drr_checker u_drr_checker (.*);

// ----- tb/sv/tb_reorder_pkg.sv -----
// ----------------------------------------------------------------------------
// tb_reorder_pkg
// beat type and scoreboard of the receive reorder testbench: tracks the
// expected number and parked slots of every channel and queues the beats
// that each accepted packet must produce
// ----------------------------------------------------------------------------
package tb_reorder_pkg;

    import drr_pkg::*;

    localparam int NUM_CH      = DEF_CHANNELS;
    localparam int WIN         = DEF_WINDOW;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        result_kind_t          kind;
        logic [CHAN_W-1:0]     chan;
        logic [SEQ_W-1:0]      idx;
        logic [HANDLE_W-1:0]   handle;
        ack_status_t           status;
        logic                  tail;
    } reorder_beat_t;

    class reorder_scoreboard;

        logic [SEQ_W-1:0]    want_seq [NUM_CH];
        bit                  parked [NUM_CH][WIN];
        logic [HANDLE_W-1:0] parked_handle [NUM_CH][WIN];
        reorder_beat_t       pending [$];
        int                  faults;

        function new();
            faults = 0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                want_seq[c] = '0;
                for (int s = 0; s < WIN; s++)
                begin
                    parked[c][s]        = 1'b0;
                    parked_handle[c][s] = '0;
                end
            end
        endfunction

        function void push_beat(result_kind_t kind, logic [CHAN_W-1:0] ch,
                                logic [SEQ_W-1:0] idx, logic [HANDLE_W-1:0] h,
                                ack_status_t st);
            reorder_beat_t b;
            b.kind   = kind;
            b.chan   = ch;
            b.idx    = idx;
            b.handle = h;
            b.status = st;
            b.tail   = 1'b0;
            pending.insert(pending.size(), b);
        endfunction

        // predict every beat caused by one accepted packet
        function void note_packet(logic [CHAN_W-1:0] ch, logic [SEQ_W-1:0] idx,
                                  logic [HANDLE_W-1:0] h);
            logic [SEQ_W-1:0] gap;
            logic [SEQ_W-1:0] walk;
            int               drained;
            if (ch >= NUM_CH)
            begin
                push_beat(RK_ACK, ch, idx, '0, ST_BEYOND);
            end
            else
            begin
                gap = idx - want_seq[ch];
                if (gap == 0)
                begin
                    push_beat(RK_ACK, ch, idx, '0, ST_IN_ORDER);
                    parked[ch][idx % WIN] = 1'b0;
                    push_beat(RK_DELIVER, ch, idx, h, ST_IN_ORDER);
                    walk    = idx + 16'd1;
                    drained = 0;
                    while (drained < WIN - 1 && parked[ch][walk % WIN])
                    begin
                        push_beat(RK_DELIVER, ch, walk, parked_handle[ch][walk % WIN],
                                  ST_IN_ORDER);
                        parked[ch][walk % WIN] = 1'b0;
                        walk    = walk + 16'd1;
                        drained = drained + 1;
                    end
                    want_seq[ch] = walk;
                end
                else if (gap < WIN)
                begin
                    parked[ch][idx % WIN]        = 1'b1;
                    parked_handle[ch][idx % WIN] = h;
                    push_beat(RK_ACK, ch, idx, '0, ST_BUFFERED);
                end
                else if (gap < DUP_LIMIT)
                begin
                    push_beat(RK_ACK, ch, idx, '0, ST_BEYOND);
                end
                else
                begin
                    push_beat(RK_ACK, ch, idx, '0, ST_DUPLICATE);
                end
            end
            pending[pending.size() - 1].tail = 1'b1;
        endfunction

        function void check_beat(reorder_beat_t got);
            reorder_beat_t want;
            if (pending.size() == 0)
            begin
                if (faults < MAX_REPORTS)
                    $display("unexpected beat: kind=%0d ch=%0d idx=%h hdl=%h st=%0d last=%0d",
                             got.kind, got.chan, got.idx, got.handle, got.status, got.tail);
                faults++;
            end
            else
            begin
                want = pending.pop_front();
                if (got.kind !== want.kind || got.chan !== want.chan ||
                    got.idx !== want.idx || got.handle !== want.handle ||
                    got.status !== want.status || got.tail !== want.tail)
                begin
                    if (faults < MAX_REPORTS)
                    begin
                        $display("mismatch want: kind=%0d ch=%0d idx=%h hdl=%h st=%0d last=%0d",
                                 want.kind, want.chan, want.idx, want.handle, want.status,
                                 want.tail);
                        $display("          got: kind=%0d ch=%0d idx=%h hdl=%h st=%0d last=%0d",
                                 got.kind, got.chan, got.idx, got.handle, got.status,
                                 got.tail);
                    end
                    faults++;
                end
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives packets into the receive reorder engine, predicts acks, in-order
// deliveries and slot drains per channel, and checks every output beat in order
// ----------------------------------------------------------------------------
module tb_top;

    import drr_pkg::*;
    import tb_reorder_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 135;
    localparam int TAIL_CYCLES  = 60;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [CHAN_W-1:0]   channel        = '0;
    logic [SEQ_W-1:0]    seq_index      = '0;
    logic [HANDLE_W-1:0] payload_handle = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic                result_kind;
    logic [CHAN_W-1:0]   out_channel;
    logic [SEQ_W-1:0]    out_index;
    logic [HANDLE_W-1:0] out_handle;
    logic [1:0]          ack_status;
    logic                last;

    reorder_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int packets_sent  = 0;
    int holds_asked   = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    drw_receive_reorder_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .channel        (channel),
        .seq_index      (seq_index),
        .payload_handle (payload_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .out_channel    (out_channel),
        .out_index      (out_index),
        .out_handle     (out_handle),
        .ack_status     (ack_status),
        .last           (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        reorder_beat_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind   = result_kind_t'(result_kind);
            got.chan   = out_channel;
            got.idx    = out_index;
            got.handle = out_handle;
            got.status = ack_status_t'(ack_status);
            got.tail   = last;
            sb.check_beat(got);
        end
    end

    // one packet beat; the idle gap is chosen before valid rises
    task automatic send_packet(input logic [CHAN_W-1:0] ch, input logic [SEQ_W-1:0] idx,
                               input logic [HANDLE_W-1:0] h);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        channel        <= ch;
        seq_index      <= idx;
        payload_handle <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_packet(ch, idx, h);
        packets_sent = packets_sent + 1;
    endtask

    // park depth indices ahead in shuffled order, then send the missing head
    task automatic send_burst(input logic [CHAN_W-1:0] ch, input int depth);
        logic [SEQ_W-1:0] head;
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] swap;
        int               i;
        int               j;
        head = sb.want_seq[ch];
        for (i = 1; i <= depth; i++)
            order.insert(order.size(), head + 16'(i));
        for (i = depth - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (i = 0; i < depth; i++)
            send_packet(ch, order[i], 10'($urandom_range(0, 1023)));
        send_packet(ch, head, 10'($urandom_range(0, 1023)));
    endtask

    task automatic send_random_packet();
        logic [CHAN_W-1:0] ch;
        logic [SEQ_W-1:0]  base;
        logic [SEQ_W-1:0]  idx;
        int                pick;
        ch   = 3'($urandom_range(0, 7));
        base = sb.want_seq[ch];
        pick = $urandom_range(0, 99);
        if (pick < 35)
            idx = base;
        else if (pick < 65)
            idx = base + 16'($urandom_range(1, WIN - 1));
        else if (pick < 78)
            idx = base - 16'($urandom_range(1, 32768));
        else if (pick < 90)
            idx = base + 16'($urandom_range(WIN, 32767));
        else
            idx = 16'($urandom());
        send_packet(ch, idx, 10'($urandom_range(0, 1023)));
    endtask

    initial
    begin
        int phase;
        int first_burst;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 80;

        // in order, park, overwrite a parked slot, then drain it
        send_packet(3'd0, 16'd0, 10'h3ff);
        send_packet(3'd0, 16'd2, 10'h000);
        send_packet(3'd0, 16'd2, 10'h155);
        send_packet(3'd0, 16'd1, 10'h2aa);
        // duplicates, farthest beyond and window edges
        send_packet(3'd0, 16'd0, 10'h001);
        send_packet(3'd0, 16'h8003, 10'h3ff);
        send_packet(3'd0, 16'h8002, 10'h200);
        send_packet(3'd0, 16'd35, 10'h100);
        send_packet(3'd0, 16'd34, 10'h0f0);
        send_packet(3'd1, 16'hffff, 10'h3ff);
        send_packet(3'd1, 16'd31, 10'h00f);
        send_packet(3'd1, 16'd32, 10'h3c0);
        send_packet(3'd3, 16'd0, 10'h000);
        send_packet(3'd7, 16'd1, 10'h2ab);
        send_packet(3'd7, 16'd0, 10'h154);
        send_packet(3'd0, 16'd3, 10'h333);

        first_burst = 1;
        for (phase = 1; phase <= 3; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 9;
            end
            else if (phase == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                holds_asked   = holds_asked + 1;
            end
            while (packets_sent < 16 + phase * PHASE_ITEMS)
            begin
                if (first_burst != 0)
                begin
                    // full window: ack, delivery and the longest drain
                    first_burst = 0;
                    send_burst(3'd6, WIN - 1);
                end
                else if ($urandom_range(0, 99) < 30)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_burst(3'($urandom_range(0, 7)), WIN - 1);
                    else
                        send_burst(3'($urandom_range(0, 7)), $urandom_range(1, 8));
                end
                else
                begin
                    send_random_packet();
                end
            end
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.faults == 0 && sb.pending.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
